### design/pshh_pkg.sv
// Shared types and constants for the pc sample hash histogram.
// No dependencies; imported by the front, back, top level and checker.
package pshh_pkg;

  // Field widths
  localparam int PC_W  = 64;
  localparam int IDX_W = 12;
  localparam int CNT_W = 32;
  localparam int CTR_W = 64;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 240;
  localparam int OUT_PAD_W  = OUT_DATA_W - (IDX_W + PC_W + CNT_W + 2 * CTR_W);

  // Default parameter values
  localparam int SLOT_BITS_DEF   = 12;
  localparam int PROBE_LIMIT_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;

  // Hash constants
  localparam logic [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
  localparam int          HASH_SHIFT = 40;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request kinds carried on in_tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result kinds carried on out_tuser
  typedef enum logic [1:0] {
    ST_INSERT = 2'd0,
    ST_INCR   = 2'd1,
    ST_LOST   = 2'd2,
    ST_READ   = 2'd3
  } status_t;

endpackage

### design/pshh_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the key and count tables.
module pshh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### design/pshh_fifo.sv
// Small register queue between the request front end and the table engine.
// No dependencies.
module pshh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill_r == FILL_W'(DEPTH));
  assign valid    = (fill_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

### design/pshh_front.sv
// Request front end: accepts requests, hashes sample pcs, queues table jobs.
// Depends on pshh_pkg.
module pshh_front #(
  parameter int SLOT_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,
  input  logic [pshh_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            clr_done,
  output logic                            q_push,
  output logic [SLOT_BITS+pshh_pkg::PC_W:0] q_data,
  input  logic                            q_full
);

  import pshh_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_MUL2,
    F_SUM,
    F_PUSH
  } fstate_t;

  fstate_t               state_r;
  logic                  mode_r;
  logic [PC_W-1:0]       pc_r;
  logic [SLOT_BITS-1:0]  addr_r;
  logic [63:0]           prod_r;
  logic [31:0]           acc_r;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           prod;
  logic [31:0]           hsum;
  logic [31:0]           hshift;
  logic [SLOT_BITS+IDX_W-1:0] idx_ext;
  logic                  accept;

  assign in_tready = (state_r == F_IDLE) && clr_done;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = (state_r == F_PUSH);
  assign q_data    = {addr_r, pc_r, mode_r};

  // Pick partial-product operands; (pc>>2) splits into a low and a high word
  always_comb begin
    case (state_r)
      F_MUL0: begin
        mul_a = pc_r[33:2];
        mul_b = GOLDEN[31:0];
      end
      F_MUL1: begin
        mul_a = {2'b00, pc_r[63:34]};
        mul_b = GOLDEN[31:0];
      end
      default: begin
        mul_a = pc_r[33:2];
        mul_b = GOLDEN[63:32];
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign hsum    = acc_r + prod_r[31:0];
  assign hshift  = hsum >> (HASH_SHIFT - 32);
  assign idx_ext = {{SLOT_BITS{1'b0}}, in_tdata[PC_W +: IDX_W]};

  // Sequence the hash over three partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            mode_r <= in_tuser;
            pc_r   <= in_tdata[PC_W-1:0];
            addr_r <= idx_ext[SLOT_BITS-1:0];
            state_r <= (in_tuser == MODE_READ) ? F_PUSH : F_MUL0;
          end
        end
        F_MUL0: begin
          prod_r  <= prod;
          state_r <= F_MUL1;
        end
        F_MUL1: begin
          acc_r   <= prod_r[63:32];
          prod_r  <= prod;
          state_r <= F_MUL2;
        end
        F_MUL2: begin
          acc_r   <= hsum;
          prod_r  <= prod;
          state_r <= F_SUM;
        end
        F_SUM: begin
          addr_r  <= hshift[SLOT_BITS-1:0];
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### design/pshh_back.sv
// Table engine: clears the count table, probes, updates and reads slots.
// Depends on pshh_pkg and pshh_ram; holds the output register.
module pshh_back #(
  parameter int SLOT_BITS   = 12,
  parameter int PROBE_LIMIT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [SLOT_BITS+pshh_pkg::PC_W:0] q_data,
  output logic                              clr_done,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [1:0]                        out_tuser,
  output logic [pshh_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import pshh_pkg::*;

  localparam int DEPTH = 1 << SLOT_BITS;
  localparam int PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE,
    B_READ,
    B_EMIT
  } bstate_t;

  bstate_t              state_r;
  logic [SLOT_BITS-1:0] clr_addr_r;
  logic [PC_W-1:0]      pc_r;
  logic [SLOT_BITS-1:0] addr_r;
  logic [PW-1:0]        idx_r;
  logic [CTR_W-1:0]     total_r;
  logic [CTR_W-1:0]     lost_r;

  status_t              res_status_r;
  logic [SLOT_BITS-1:0] res_slot_r;
  logic [PC_W-1:0]      res_key_r;
  logic [CNT_W-1:0]     res_count_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [IDX_W-1:0]     out_slot_r;
  logic [PC_W-1:0]      out_key_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [CTR_W-1:0]     out_total_r;
  logic [CTR_W-1:0]     out_lost_r;

  logic                 q_mode;
  logic [PC_W-1:0]      q_pc;
  logic [SLOT_BITS-1:0] q_addr;

  logic [SLOT_BITS-1:0] ram_addr;
  logic                 key_we;
  logic                 cnt_we;
  logic [CNT_W-1:0]     cnt_wd;
  logic [PC_W-1:0]      key_rd;
  logic [CNT_W-1:0]     cnt_rd;

  logic                 slot_empty;
  logic                 slot_match;
  logic                 last_probe;
  logic [CNT_W-1:0]     cnt_sat;
  logic                 out_free;
  logic [SLOT_BITS+IDX_W-1:0] slot_ext;

  assign q_mode = q_data[0];
  assign q_pc   = q_data[PC_W:1];
  assign q_addr = q_data[PC_W+1 +: SLOT_BITS];

  assign slot_empty = (cnt_rd == '0);
  assign slot_match = (key_rd == pc_r);
  assign last_probe = (idx_r == PW'(PROBE_LIMIT - 1));
  assign cnt_sat    = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign slot_ext   = {{IDX_W{1'b0}}, res_slot_r};

  assign clr_done = (state_r != B_CLEAR);
  assign q_pop    = (state_r == B_IDLE) && q_valid;

  // Drive the table port: clear sweep, probe reads, insert and hit writes
  always_comb begin
    ram_addr = addr_r;
    key_we   = 1'b0;
    cnt_we   = 1'b0;
    cnt_wd   = '0;
    case (state_r)
      B_CLEAR: begin
        ram_addr = clr_addr_r;
        cnt_we   = 1'b1;
      end
      B_IDLE: begin
        ram_addr = q_addr;
      end
      B_PROBE: begin
        if (slot_empty) begin
          key_we = 1'b1;
          cnt_we = 1'b1;
          cnt_wd = CNT_W'(1);
        end else if (slot_match) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_sat;
        end else if (!last_probe) begin
          ram_addr = addr_r + 1'b1;
        end
      end
      default: begin
        ram_addr = addr_r;
      end
    endcase
  end

  pshh_ram #(
    .WIDTH (PC_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (pc_r),
    .rdata (key_rd)
  );

  pshh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (ram_addr),
    .wdata (cnt_wd),
    .rdata (cnt_rd)
  );

  // Sequence jobs and hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      total_r     <= '0;
      lost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the delivered result unless a new one loads this cycle
      if (out_valid_r && out_tready && (state_r != B_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            pc_r   <= q_pc;
            addr_r <= q_addr;
            idx_r  <= '0;
            if (q_mode == MODE_READ) begin
              state_r <= B_READ;
            end else begin
              total_r <= total_r + 1'b1;
              state_r <= B_PROBE;
            end
          end
        end
        B_PROBE: begin
          if (slot_empty) begin
            res_status_r <= ST_INSERT;
            res_slot_r   <= addr_r;
            res_key_r    <= pc_r;
            res_count_r  <= CNT_W'(1);
            state_r      <= B_EMIT;
          end else if (slot_match) begin
            res_status_r <= ST_INCR;
            res_slot_r   <= addr_r;
            res_key_r    <= pc_r;
            res_count_r  <= cnt_sat;
            state_r      <= B_EMIT;
          end else if (last_probe) begin
            res_status_r <= ST_LOST;
            res_slot_r   <= '0;
            res_key_r    <= '0;
            res_count_r  <= '0;
            lost_r       <= lost_r + 1'b1;
            state_r      <= B_EMIT;
          end else begin
            addr_r <= addr_r + 1'b1;
            idx_r  <= idx_r + 1'b1;
          end
        end
        B_READ: begin
          res_status_r <= ST_READ;
          res_slot_r   <= addr_r;
          res_key_r    <= slot_empty ? '0 : key_rd;
          res_count_r  <= cnt_rd;
          state_r      <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= slot_ext[IDX_W-1:0];
            out_key_r    <= res_key_r;
            out_count_r  <= res_count_r;
            out_total_r  <= total_r;
            out_lost_r   <= lost_r;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_lost_r, out_total_r, out_count_r,
                       out_key_r, out_slot_r};

endmodule

### design/pc_sample_hash_histogram.sv
// Top level of the pc sample hash histogram: front end, job queue, table engine.
// Depends on pshh_pkg, pshh_front, pshh_fifo and pshh_back.
//
// Each request gives exactly one result. A sample request (in_tuser = 0) hashes
// its pc in the front end through states F_MUL0, F_MUL1, F_MUL2 and F_SUM with
// one shared 32x32 multiplier and is queued from F_PUSH; the table engine then
// reads one probe slot per cycle from the single-port tables, up to PROBE_LIMIT
// probed slots, and the front end hashes the next sample in the meantime. A read
// request reads its given slot without probing. After reset the engine sweeps
// all 2^SLOT_BITS slots of the count table to zero, one slot a cycle, and holds
// in_tready low until the sweep ends.
// Counts saturate at 2^32-1.
module pc_sample_hash_histogram #(
  parameter int SLOT_BITS   = pshh_pkg::SLOT_BITS_DEF,
  parameter int PROBE_LIMIT = pshh_pkg::PROBE_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,   // mode
  input  logic [pshh_pkg::IN_DATA_W-1:0]   in_tdata,   // pc, slot_index, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [1:0]                       out_tuser,  // status
  // slot, entry_key, entry_count, total_samples, lost_samples, zero pad
  output logic [pshh_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import pshh_pkg::*;

  localparam int ENT_W = 1 + PC_W + SLOT_BITS;

  logic             clr_done;
  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [ENT_W-1:0] q_pop_data;
  logic             q_valid;

  pshh_front #(
    .SLOT_BITS (SLOT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .clr_done  (clr_done),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  pshh_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .valid     (q_valid)
  );

  pshh_back #(
    .SLOT_BITS   (SLOT_BITS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_pop_data),
    .clr_done   (clr_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

### design/pshh_checker.sv
// Port-level checks for the pc sample hash histogram, bound to the top level.
// Depends on pshh_pkg and pc_sample_hash_histogram.
module pshh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [1:0]                      out_tuser,
  input logic [pshh_pkg::OUT_DATA_W-1:0] out_tdata
);

  import pshh_pkg::*;

  logic             in_acc;
  logic             out_acc;
  logic [3:0]       pend_r;
  logic [CTR_W-1:0] prev_total_r;
  logic [IDX_W-1:0] f_slot;
  logic [PC_W-1:0]  f_key;
  logic [CNT_W-1:0] f_count;
  logic [CTR_W-1:0] f_total;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign f_slot  = out_tdata[IDX_W-1:0];
  assign f_key   = out_tdata[IDX_W +: PC_W];
  assign f_count = out_tdata[IDX_W+PC_W +: CNT_W];
  assign f_total = out_tdata[IDX_W+PC_W+CNT_W +: CTR_W];

  // Track requests in flight and the last delivered total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      prev_total_r <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_r <= pend_r + 1'b1;
      end else if (out_acc && !in_acc) begin
        pend_r <= pend_r - 1'b1;
      end
      if (out_acc) begin
        prev_total_r <= f_total;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result without a pending request");

  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tuser == ST_LOST |-> f_slot == '0 && f_key == '0 && f_count == '0)
    else $error("lost result carries slot data");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> f_total == prev_total_r || f_total == prev_total_r + 1'b1)
    else $error("sample total skipped");

endmodule

bind pc_sample_hash_histogram pshh_checker u_pshh_checker (.*);
